[hw/rtl/xxh32_pkg.sv]
// Package for the streaming 32-bit xxHash block: primes, beat classes and the
// queue item carried from the front end to the back end. No dependencies.
package xxh32_pkg;

	localparam logic [31:0] PR1 = 32'h9E3779B1;
	localparam logic [31:0] PR2 = 32'h85EBCA77;
	localparam logic [31:0] PR3 = 32'hC2B2AE3D;
	localparam logic [31:0] PR4 = 32'h27D4EB2F;
	localparam logic [31:0] PR5 = 32'h165667B1;

	// What the back end must do with one beat
	typedef enum logic [1:0] {
		OP_BUFFER,       // park word in the stripe buffer
		OP_STRIPE,       // word completes a stripe: run the four lane rounds
		OP_FINAL,        // last word: finish the hash
		OP_FINAL_STRIPE  // last full word completing a stripe: lane rounds, then finish
	} xxh32_op_t;

	typedef struct packed {
		xxh32_op_t   op;
		logic [31:0] word;
		logic [2:0]  nb;    // valid bytes, already saturated to 0..4
	} xxh32_item_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
	endfunction

endpackage

[hw/rtl/xxh32_front.sv]
// Front end: accepts input beats and classifies each one for the back end.
// Depends on xxh32_pkg.
module xxh32_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [2:0]            s_tuser,
	input  logic                  s_tlast,
	output logic                  push_valid,
	input  logic                  push_ready,
	output xxh32_pkg::xxh32_item_t push_item
);
	import xxh32_pkg::*;

	logic [1:0] fill_q;
	logic [2:0] nb_sat;
	logic       accept;

	always_comb begin
		if (s_tuser inside {[3'd5:3'd7]}) begin
			nb_sat = 3'd4;
		end else begin
			nb_sat = s_tuser;
		end
	end

	always_comb begin
		push_item.word = s_tdata;
		push_item.nb   = nb_sat;
		if (!s_tlast) begin
			push_item.op = (fill_q == 2'd3) ? OP_STRIPE : OP_BUFFER;
		end else if (nb_sat == 3'd4 && fill_q == 2'd3) begin
			push_item.op = OP_FINAL_STRIPE;
		end else begin
			push_item.op = OP_FINAL;
		end
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;
	assign accept     = s_tvalid && push_ready;

	// Track the stripe fill as the back end will see it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept) begin
			if (s_tlast) begin
				fill_q <= 2'd0;
			end else begin
				fill_q <= fill_q + 2'd1;
			end
		end
	end

endmodule

[hw/rtl/xxh32_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on xxh32_pkg for the item type.
module xxh32_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  xxh32_pkg::xxh32_item_t push_item,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output xxh32_pkg::xxh32_item_t pop_item
);
	import xxh32_pkg::*;

	xxh32_item_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push_ok;
	logic        pop_ok;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push_ok    = push_valid && push_ready;
	assign pop_ok     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 2'd1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hw/rtl/xxh32_back.sv]
// Back end: sequencer around one shared 32x32 multiplier that runs lane rounds,
// the final fold and the avalanche, with the result register. Depends on xxh32_pkg.
module xxh32_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           seed,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  xxh32_pkg::xxh32_item_t item,
	output logic                  hash_valid,
	input  logic                  hash_ready,
	output logic [31:0]           hash_value
);
	import xxh32_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_MUL1, ST_ROT, ST_MUL2, ST_START, ST_MERGE,
		ST_ADDLEN, ST_TAIL, ST_AV1, ST_AV2, ST_AV3
	} state_t;

	typedef enum logic [1:0] {K_LANE, K_WORD, K_TAIL, K_BYTE} kind_t;

	state_t      state_q;
	kind_t       kind_q;
	logic [1:0]  idx_q;
	logic [1:0]  fill_q;
	logic [31:0] len_q;
	logic        long_q;
	logic        hash_valid_q;
	logic [31:0] hash_value_q;

	xxh32_item_t op_q;
	logic [31:0] lane_q [4];
	logic [31:0] buf_q  [3];
	logic [31:0] h_q;
	logic [31:0] prod_q;

	logic [2:0]  nb_eff;
	logic [31:0] round_word;
	logic [31:0] k1, k2, base;
	logic [4:0]  rot_amt;
	logic [31:0] mul_a, mul_b, mul_p;
	logic [31:0] rot_sum;
	logic [31:0] merge_rot;
	logic        out_free;

	assign nb_eff     = (op_q.op == OP_FINAL_STRIPE) ? 3'd0 : op_q.nb;
	assign item_ready = (state_q == ST_IDLE);
	assign out_free   = !hash_valid_q || hash_ready;
	assign hash_valid = hash_valid_q;
	assign hash_value = hash_value_q;

	always_comb begin
		case (kind_q)
			K_LANE: begin
				round_word = (idx_q == 2'd3) ? op_q.word : buf_q[idx_q];
				k1 = PR2; k2 = PR1; rot_amt = 5'd13; base = lane_q[idx_q];
			end
			K_WORD: begin
				round_word = buf_q[idx_q];
				k1 = PR3; k2 = PR4; rot_amt = 5'd17; base = h_q;
			end
			K_TAIL: begin
				round_word = op_q.word;
				k1 = PR3; k2 = PR4; rot_amt = 5'd17; base = h_q;
			end
			default: begin
				round_word = {24'd0, op_q.word[{idx_q, 3'b000} +: 8]};
				k1 = PR5; k2 = PR1; rot_amt = 5'd11; base = h_q;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = round_word; mul_b = k1;
			end
			ST_AV1: begin
				mul_a = h_q ^ (h_q >> 15); mul_b = PR2;
			end
			ST_AV2: begin
				mul_a = prod_q ^ (prod_q >> 13); mul_b = PR3;
			end
			default: begin
				mul_a = prod_q; mul_b = k2;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign rot_sum = rotl(base + prod_q, rot_amt);

	always_comb begin
		case (idx_q)
			2'd1:    merge_rot = rotl(lane_q[1], 5'd7);
			2'd2:    merge_rot = rotl(lane_q[2], 5'd12);
			2'd3:    merge_rot = rotl(lane_q[3], 5'd18);
			default: merge_rot = rotl(lane_q[0], 5'd1);
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					op_q <= item;
					if (item.op == OP_BUFFER) begin
						buf_q[fill_q] <= item.word;
					end
				end
			end
			ST_LOAD: begin
				lane_q[0] <= seed + PR1 + PR2;
				lane_q[1] <= seed + PR2;
				lane_q[2] <= seed;
				lane_q[3] <= seed - PR1;
			end
			ST_MUL1, ST_AV1, ST_AV2: prod_q <= mul_p;
			ST_ROT: prod_q <= rot_sum;
			ST_MUL2: begin
				if (kind_q == K_LANE) begin
					lane_q[idx_q] <= mul_p;
				end else begin
					h_q <= mul_p;
				end
			end
			ST_START:  h_q <= long_q ? rotl(lane_q[0], 5'd1) : seed + PR5;
			ST_MERGE:  h_q <= h_q + merge_rot;
			ST_ADDLEN: h_q <= h_q + len_q;
			default: ;
		endcase
	end

	// Sequencer, message state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= K_LANE;
			idx_q        <= 2'd0;
			fill_q       <= 2'd0;
			len_q        <= 32'd0;
			long_q       <= 1'b0;
			hash_valid_q <= 1'b0;
			hash_value_q <= 32'd0;
		end else begin
			if (state_q == ST_AV3 && out_free) begin
				hash_valid_q <= 1'b1;
			end else if (hash_ready) begin
				hash_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.op)
							OP_BUFFER: begin
								fill_q <= fill_q + 2'd1;
								len_q  <= len_q + 32'd4;
							end
							OP_FINAL: begin
								len_q   <= len_q + {29'd0, item.nb};
								state_q <= ST_START;
							end
							default: begin
								len_q   <= len_q + 32'd4;
								kind_q  <= K_LANE;
								idx_q   <= 2'd0;
								state_q <= long_q ? ST_MUL1 : ST_LOAD;
							end
						endcase
					end
				end
				ST_LOAD: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_ROT;
				ST_ROT:  state_q <= ST_MUL2;
				ST_MUL2: begin
					case (kind_q)
						K_LANE: begin
							if (idx_q == 2'd3) begin
								long_q  <= 1'b1;
								fill_q  <= 2'd0;
								state_q <= (op_q.op == OP_FINAL_STRIPE) ? ST_START : ST_IDLE;
							end else begin
								idx_q   <= idx_q + 2'd1;
								state_q <= ST_MUL1;
							end
						end
						K_WORD: begin
							if ({1'b0, idx_q} + 3'd1 < {1'b0, fill_q}) begin
								idx_q   <= idx_q + 2'd1;
								state_q <= ST_MUL1;
							end else begin
								state_q <= ST_TAIL;
							end
						end
						K_TAIL: state_q <= ST_AV1;
						default: begin
							if ({1'b0, idx_q} + 3'd1 < nb_eff) begin
								idx_q   <= idx_q + 2'd1;
								state_q <= ST_MUL1;
							end else begin
								state_q <= ST_AV1;
							end
						end
					endcase
				end
				ST_START: begin
					idx_q   <= 2'd1;
					state_q <= long_q ? ST_MERGE : ST_ADDLEN;
				end
				ST_MERGE: begin
					if (idx_q == 2'd3) begin
						state_q <= ST_ADDLEN;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_ADDLEN: begin
					if (fill_q != 2'd0) begin
						kind_q  <= K_WORD;
						idx_q   <= 2'd0;
						state_q <= ST_MUL1;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					idx_q <= 2'd0;
					if (nb_eff == 3'd4) begin
						kind_q  <= K_TAIL;
						state_q <= ST_MUL1;
					end else if (nb_eff == 3'd0) begin
						state_q <= ST_AV1;
					end else begin
						kind_q  <= K_BYTE;
						state_q <= ST_MUL1;
					end
				end
				ST_AV1: state_q <= ST_AV2;
				ST_AV2: state_q <= ST_AV3;
				ST_AV3: begin
					if (out_free) begin
						hash_value_q <= prod_q ^ (prod_q >> 16);
						fill_q       <= 2'd0;
						len_q        <= 32'd0;
						long_q       <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AV3 && out_free) |=> (fill_q == 2'd0 && len_q == 32'd0 && !long_q))
		else $error("message state not cleared after emitting a hash");

	a_byte_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1 && kind_q == K_BYTE) |-> (nb_eff != 3'd0 && nb_eff != 3'd4))
		else $error("byte fold started with no partial tail");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash_valid_q) |-> $past(state_q) == ST_AV3)
		else $error("result raised outside the avalanche step");
`endif

endmodule

[hw/rtl/xxhash32_stream_hasher.sv]
// Top level of the streaming 32-bit xxHash block: seed register, front end,
// item queue and back end. Depends on xxh32_pkg, xxh32_front, xxh32_queue, xxh32_back.
//
//   channel   direction  beat handshake        payload
//   s_*       in         s_tvalid & s_tready   s_tdata word, s_tuser byte count, s_tlast
//   m_*       out        m_tvalid & m_tready   m_tdata hash
//   seed_*    in         seed_we               seed_wdata
//
// A non-final beat that only parks a word is handled in the back end's idle state; a beat that
// completes a stripe is taken, loads the lanes on the first stripe of a message, then runs
// multiply/rotate/multiply for each lane.
// A final beat runs the start step, the merge (if a stripe was consumed), the length add,
// a multiply/rotate/multiply fold per buffered word and per tail byte (or one for a full word)
// and the avalanche steps; one that completes a stripe runs the lane rounds first and leaves no tail to fold.
// The last avalanche step holds while the result register is still full.
// Reset clears the seed to zero and empties the queue and message state; no clearing pass.
// The two-entry queue lets the source keep feeding while the back end works, and the
// result register holds a finished hash while the next message is already being taken.
module xxhash32_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // [31:0] data_word
	input  logic [2:0]  s_tuser,     // [2:0] byte_count
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [31:0] hash_value
	input  logic        seed_we,
	input  logic [31:0] seed_wdata
);
	import xxh32_pkg::*;

	logic [31:0] seed_q;

	logic        push_valid, push_ready;
	xxh32_item_t push_item;
	logic        pop_valid, pop_ready;
	xxh32_item_t pop_item;

	// Hold the seed; the user must write it only while the block is idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	// Classify each beat against the running stripe fill
	xxh32_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Decouple the input side from the multi-cycle back end
	xxh32_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Run lane rounds, finish and avalanche; drive the result register
	xxh32_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.hash_valid (m_tvalid),
		.hash_ready (m_tready),
		.hash_value (m_tdata)
	);

endmodule

[tb/xxh32_checker.sv]
// Scoreboard for the streaming xxHash32 block: watches the input, output and seed ports,
// predicts each message hash and compares it with the emitted one.
// Depends on xxh32_pkg for the five primes.
module xxh32_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,     // [31:0] data_word
	input  logic [2:0]  s_tuser,     // [2:0] byte_count
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,     // [31:0] hash_value
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	output int          fail_count,
	output int          hashes_waiting,
	output int          hashes_checked
);

	import xxh32_pkg::*;

	logic [31:0] seed_now;
	logic [31:0] lane [4];
	logic [31:0] stripe_word [3];
	logic [1:0]  fill;
	logic [31:0] len_bytes;
	logic        long_msg;
	logic [31:0] hash_due [$];
	logic [31:0] want;
	int          shown;

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		if (n == 0)
			return v;
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] lane_round(input logic [31:0] acc, input logic [31:0] w);
		return rol32(acc + w * PR2, 13) * PR1;
	endfunction

	function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
		return rol32(h + w * PR3, 17) * PR4;
	endfunction

	task automatic consume_stripe(input logic [31:0] w3);
		// lanes take the seed only when the first stripe of a message lands
		if (!long_msg) begin
			lane[0] = seed_now + PR1 + PR2;
			lane[1] = seed_now + PR2;
			lane[2] = seed_now;
			lane[3] = seed_now - PR1;
		end
		lane[0] = lane_round(lane[0], stripe_word[0]);
		lane[1] = lane_round(lane[1], stripe_word[1]);
		lane[2] = lane_round(lane[2], stripe_word[2]);
		lane[3] = lane_round(lane[3], w3);
		long_msg = 1'b1;
		fill = 2'd0;
	endtask

	task automatic absorb_beat(input logic [31:0] w, input logic [2:0] bc, input logic fin);
		logic [31:0] h;
		logic [2:0]  nb;
		int          i;
		if (!fin) begin
			len_bytes += 32'd4;
			if (fill == 2'd3)
				consume_stripe(w);
			else begin
				stripe_word[fill] = w;
				fill++;
			end
		end else begin
			nb = (bc > 3'd4) ? 3'd4 : bc;
			len_bytes += {29'd0, nb};
			if (nb == 3'd4 && fill == 2'd3) begin
				consume_stripe(w);
				nb = 3'd0;
			end
			if (long_msg)
				h = rol32(lane[0], 1) + rol32(lane[1], 7) + rol32(lane[2], 12)
					+ rol32(lane[3], 18);
			else
				h = seed_now + PR5;
			h += len_bytes;
			for (i = 0; i < fill; i++)
				h = fold_word(h, stripe_word[i]);
			if (nb == 3'd4)
				h = fold_word(h, w);
			else
				for (i = 0; i < nb; i++)
					h = rol32(h + w[8*i +: 8] * PR5, 11) * PR1;
			h ^= h >> 15;
			h *= PR2;
			h ^= h >> 13;
			h *= PR3;
			h ^= h >> 16;
			hash_due = {hash_due, h};
			fill = 2'd0;
			len_bytes = 32'd0;
			long_msg = 1'b0;
		end
	endtask

	task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		fail_count++;
		if (shown < 10) begin
			shown++;
			$display("mismatch: %s expected %h got %h", what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_now = 32'd0;
			for (int k = 0; k < 4; k++)
				lane[k] = 32'd0;
			fill = 2'd0;
			len_bytes = 32'd0;
			long_msg = 1'b0;
			hash_due.delete();
			fail_count = 0;
			hashes_checked = 0;
			hashes_waiting = 0;
			shown = 0;
		end else begin
			// results first: a hash leaving now belongs to an older message
			if (m_tvalid && m_tready) begin
				if (hash_due.size() == 0)
					report("hash with none outstanding", 32'd0, m_tdata);
				else begin
					want = hash_due.pop_front();
					if (want !== m_tdata)
						report("hash", want, m_tdata);
					hashes_checked++;
				end
			end
			if (s_tvalid && s_tready)
				absorb_beat(s_tdata, s_tuser, s_tlast);
			if (seed_we)
				seed_now = seed_wdata;
			hashes_waiting = hash_due.size();
		end
	end

endmodule

[tb/tb.sv]
// Top of the xxHash32 regression: clock, reset, stimulus and verdict.
// Depends on xxhash32_stream_hasher (with xxh32_pkg) and xxh32_checker.
module tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        seed_we;
	logic [31:0] seed_wdata;

	int fail_count;
	int hashes_waiting;
	int hashes_checked;

	int  beats_sent;
	int  msgs_sent;
	int  seed_writes;
	bit  calm;          // set for the tail of the run: no idling on either side

	xxhash32_stream_hasher dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata)
	);

	xxh32_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.seed_we        (seed_we),
		.seed_wdata     (seed_wdata),
		.fail_count     (fail_count),
		.hashes_waiting (hashes_waiting),
		.hashes_checked (hashes_checked)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hard stop well beyond the slowest legal run
	initial begin
		#(8 * 400000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: accept by default, drop ready for random bursts until the tail
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Hold one beat on the input channel until it is taken; sometimes idle first
	task automatic send_beat(input logic [31:0] w, input logic [2:0] bc, input logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= bc;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
		if (fin)
			msgs_sent++;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Mostly short messages, a few spanning many stripes
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 8);
		else if (r < 9)
			return $urandom_range(9, 20);
		return $urandom_range(21, 48);
	endfunction

	// Non-final beats carry a random byte count: the block must ignore it
	task automatic send_body(input int n_words);
		for (int k = 0; k < n_words; k++)
			send_beat(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
	endtask

	// Drain: wait for every hash, then let in-flight non-final beats clear the back end
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (hashes_waiting == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_seed(input logic [31:0] v);
		seed_we    <= 1'b1;
		seed_wdata <= v;
		@(posedge clk);
		seed_we    <= 1'b0;
		seed_writes++;
	endtask

	initial begin
		int          phase;
		int          phase_beats;
		logic [31:0] seed_v;

		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 32'd0;
		s_tuser    = 3'd0;
		s_tlast    = 1'b0;
		seed_we    = 1'b0;
		seed_wdata = 32'd0;
		calm       = 1'b0;
		beats_sent = 0;
		msgs_sent  = 0;
		seed_writes = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset seed. Empty message: zero bytes on the only beat
		send_beat(32'hDEAD_BEEF, 3'd0, 1'b1);
		// one-word messages, each legal byte count
		send_beat(32'hFFFF_FFFF, 3'd1, 1'b1);
		send_beat(32'h0000_0000, 3'd2, 1'b1);
		send_beat(32'hA5A5_5A5A, 3'd3, 1'b1);
		send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
		// byte counts above four saturate
		send_beat(32'h1234_5678, 3'd5, 1'b1);
		send_beat(32'h8765_4321, 3'd6, 1'b1);
		send_beat(32'hFFFF_FFFF, 3'd7, 1'b1);
		// sixteen bytes: the final full word closes a stripe, nothing left over
		send_body(3);
		send_beat(32'h0000_0000, 3'd4, 1'b1);
		// three buffered words, final beat adds no bytes
		send_body(3);
		send_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
		// one stripe plus a partial tail
		send_body(4);
		send_beat(32'hC0FF_EE11, 3'd2, 1'b1);
		settle();

		// Random phases, each under its own seed; some leave a message open so that the
		// next seed write lands mid-message
		phase = 0;
		while (beats_sent < 550) begin
			case (phase % 4)
				0:       seed_v = 32'hFFFF_FFFF;
				1:       seed_v = 32'h0000_0000;
				2:       seed_v = 32'h8000_0000;
				default: seed_v = $urandom;
			endcase
			load_seed(seed_v);
			phase_beats = beats_sent;
			while (beats_sent - phase_beats < 70 && beats_sent < 550) begin
				if (beats_sent >= 470)
					calm = 1'b1;
				send_body(pick_length() - 1);
				send_beat(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
			end
			if (beats_sent < 500 && $urandom_range(0, 1) == 1)
				send_body($urandom_range(1, 7));
			settle();
			phase++;
		end
		// close any message still open from the last phase
		send_beat(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
		settle();

		$display("run covered %0d beats in %0d messages, %0d hashes compared",
			beats_sent, msgs_sent, hashes_checked);
		$display("seed loaded %0d times: all-zero, all-one, top bit, random, some mid-message",
			seed_writes);
		if (fail_count == 0 && hashes_waiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[xxhash32_stream_hasher.f]
hw/rtl/xxh32_pkg.sv
hw/rtl/xxh32_front.sv
hw/rtl/xxh32_queue.sv
hw/rtl/xxh32_back.sv
hw/rtl/xxhash32_stream_hasher.sv
tb/xxh32_checker.sv
tb/tb.sv
